FILE: rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/btf_pkg.sv
package btf_pkg;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_HDR_SMALL = 3'd1;
  localparam logic [2:0] ST_TAG_SMALL = 3'd2;
  localparam logic [2:0] ST_EMPTY_MOD = 3'd3;
  localparam logic [2:0] ST_NONE      = 3'd4;

  localparam logic [31:0] TAG_END    = 32'd0;
  localparam logic [31:0] TAG_MODULE = 32'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] mod_base;
    logic [31:0] mod_end;
  } out_item_t;

endpackage

FILE: rtl/boot_info_module_tag_finder_top.sv
// Result: registered, shown on out_data_o in the cycle after the byte that completes it.
// Throughput: one byte per cycle; input stalls only while a result waits in the
// result register and out_ready_i is low.
// Reset: asynchronous, active low; the parser idles until a byte marked as first
// and the result register is empty.
module boot_info_module_tag_finder_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  btf_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output btf_pkg::out_item_t out_data_o
);
  import btf_pkg::*;

  function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] lane,
                                           input logic [7:0] b);
    logic [31:0] w;
    w = word;
    w[lane*8 +: 8] = b;
    return w;
  endfunction

  logic [33:0] offset_q, offset_d;
  logic [31:0] size_q, size_d;
  logic [33:0] tag_start_q, tag_start_d;
  logic [31:0] tag_type_q, tag_type_d;
  logic [31:0] tag_len_q, tag_len_d;
  logic [31:0] mstart_q, mstart_d;
  logic [31:0] mend_q, mend_d;
  logic        fin_q, fin_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_data_q, out_data_d;

  logic        accept;
  logic [33:0] pos;
  logic [31:0] size_b, ttype_b, tlen_b, mstart_b, mend_b;
  logic [33:0] tstart_b;
  logic        active;
  logic        in_hdr, in_tag;
  logic [33:0] rel;
  logic [31:0] size_new, ttype_new, tlen_new, mstart_new, mend_new;
  logic [32:0] step;
  logic [33:0] tstart_next;
  logic        past_end;
  logic        emit;
  logic [2:0]  emit_status;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Restart on a first byte, else carry on from the held state.
  always_comb begin
    if (in_data_i.first_byte) begin
      pos      = '0;
      size_b   = '0;
      tstart_b = 34'd8;
      ttype_b  = '0;
      tlen_b   = '0;
      mstart_b = '0;
      mend_b   = '0;
      active   = 1'b1;
    end else begin
      pos      = offset_q;
      size_b   = size_q;
      tstart_b = tag_start_q;
      ttype_b  = tag_type_q;
      tlen_b   = tag_len_q;
      mstart_b = mstart_q;
      mend_b   = mend_q;
      active   = !fin_q;
    end
  end

  assign in_hdr     = (pos[33:2] == '0);
  assign rel        = pos - tstart_b;
  assign in_tag     = !in_hdr && (pos >= tstart_b) && (rel[33:4] == '0);
  assign size_new   = put_byte(size_b, pos[1:0], in_data_i.data_byte);
  assign ttype_new  = put_byte(ttype_b, rel[1:0], in_data_i.data_byte);
  assign tlen_new   = put_byte(tlen_b, rel[1:0], in_data_i.data_byte);
  assign mstart_new = put_byte(mstart_b, rel[1:0], in_data_i.data_byte);
  assign mend_new   = put_byte(mend_b, rel[1:0], in_data_i.data_byte);
  assign step       = ({1'b0, tlen_new} + 33'd7) & ~33'd7;
  assign tstart_next = tstart_b + {1'b0, step};
  assign past_end   = ({1'b0, tstart_next} + 35'd8) > {3'b000, size_b};

  always_comb begin
    offset_d    = offset_q;
    size_d      = size_q;
    tag_start_d = tag_start_q;
    tag_type_d  = tag_type_q;
    tag_len_d   = tag_len_q;
    mstart_d    = mstart_q;
    mend_d      = mend_q;
    fin_d       = fin_q;
    emit        = 1'b0;
    emit_status = ST_NONE;

    if (accept) begin
      offset_d    = pos + 34'd1;
      size_d      = size_b;
      tag_start_d = tstart_b;
      tag_type_d  = ttype_b;
      tag_len_d   = tlen_b;
      mstart_d    = mstart_b;
      mend_d      = mend_b;
      fin_d       = !active;
      if (!active) begin
        offset_d = offset_q;
      end else if (in_hdr) begin
        size_d = size_new;
        if (pos[1:0] == 2'd3 && size_new < 32'd16) begin
          emit        = 1'b1;
          emit_status = ST_HDR_SMALL;
        end
      end else if (in_tag) begin
        case (rel[3:2])
          2'd0: tag_type_d = ttype_new;
          2'd1: begin
            tag_len_d = tlen_new;
            if (rel[1:0] == 2'd3) begin
              if (tlen_new < 32'd8) begin
                emit        = 1'b1;
                emit_status = ST_TAG_SMALL;
              end else if (ttype_b == TAG_END) begin
                emit        = 1'b1;
                emit_status = ST_NONE;
              end else if (ttype_b != TAG_MODULE) begin
                tag_start_d = tstart_next;
                tag_type_d  = '0;
                tag_len_d   = '0;
                if (past_end) begin
                  emit        = 1'b1;
                  emit_status = ST_NONE;
                end
              end
            end
          end
          2'd2: mstart_d = mstart_new;
          2'd3: begin
            mend_d = mend_new;
            if (rel[1:0] == 2'd3) begin
              emit        = 1'b1;
              emit_status = (mend_new <= mstart_b) ? ST_EMPTY_MOD : ST_FOUND;
            end
          end
          default: mend_d = mend_b;
        endcase
      end
      if (emit) begin
        fin_d = 1'b1;
      end
    end
  end

  always_comb begin
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (emit) begin
      out_valid_d         = 1'b1;
      out_data_d.status   = emit_status;
      out_data_d.mod_base = (emit_status == ST_FOUND) ? mstart_b : 32'd0;
      out_data_d.mod_end  = (emit_status == ST_FOUND) ? mend_new : 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      size_q      <= '0;
      tag_start_q <= 34'd8;
      tag_type_q  <= '0;
      tag_len_q   <= '0;
      mstart_q    <= '0;
      mend_q      <= '0;
      fin_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      offset_q    <= offset_d;
      size_q      <= size_d;
      tag_start_q <= tag_start_d;
      tag_type_q  <= tag_type_d;
      tag_len_q   <= tag_len_d;
      mstart_q    <= mstart_d;
      mend_q      <= mend_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: rtl/btf_checker.sv
`include "assert_macros.svh"

module btf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input btf_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input btf_pkg::out_item_t out_data_o
);
  import btf_pkg::*;

  `ASSERT_IMPLY(a_status_range, clk_i, rst_ni, out_valid_o, out_data_o.status <= ST_NONE)
  `ASSERT_IMPLY(a_addr_zero, clk_i, rst_ni, out_valid_o && out_data_o.status != ST_FOUND, out_data_o.mod_base == 32'd0 && out_data_o.mod_end == 32'd0)
  `ASSERT_IMPLY(a_found_order, clk_i, rst_ni, out_valid_o && out_data_o.status == ST_FOUND, out_data_o.mod_end > out_data_o.mod_base)
  `ASSERT_IMPLY(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

endmodule

bind boot_info_module_tag_finder_top btf_checker u_btf_checker (.*);

FILE: bench/boot_info_module_tag_finder_top_tb.sv
module boot_info_module_tag_finder_top_tb;
  import btf_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RAND_ITEMS  = 950;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  boot_info_module_tag_finder_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  typedef struct packed {
    logic        marked;
    logic [31:0] total;
    logic [31:0] kind;
    logic [31:0] len;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [7:0]  nbytes;
    logic        typed;
    out_item_t   want;
  } blk_row_t;

  out_item_t   reports_due [$];
  logic [7:0]  blk_img [0:127];
  int unsigned sent_items   = 0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned src_idle_pct = 9;
  int unsigned sink_idle_pct = 50;
  bit          hold_request = 1'b0;

  // walk state
  logic [33:0] next_pos;
  logic [31:0] info_size;
  logic [33:0] tag_base;
  logic [31:0] tag_kind;
  logic [31:0] tag_len;
  logic [31:0] mod_lo;
  logic [31:0] mod_hi;
  logic        walk_done;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic void rewind_walk();
    next_pos  = '0;
    info_size = '0;
    tag_base  = 34'd8;
    tag_kind  = '0;
    tag_len   = '0;
    mod_lo    = '0;
    mod_hi    = '0;
  endfunction

  function automatic out_item_t close_walk(logic [2:0] status, logic [31:0] lo,
                                           logic [31:0] hi);
    out_item_t rep;
    rep.status   = status;
    rep.mod_base = lo;
    rep.mod_end  = hi;
    walk_done    = 1'b1;
    return rep;
  endfunction

  // Advances the walk by one byte; returns 1 when the byte completes a report.
  function automatic bit walk_info_byte(input in_item_t item, output out_item_t rep);
    logic [33:0] at;
    logic [33:0] rel;
    logic [33:0] step;
    rep = '0;
    if (item.first_byte) begin
      rewind_walk();
      walk_done = 1'b0;
    end
    if (walk_done) return 1'b0;
    at       = next_pos;
    next_pos = next_pos + 34'd1;
    if (at < 34'd4) begin
      info_size[at[1:0]*8 +: 8] = item.data_byte;
      if (at == 34'd3 && info_size < 32'd16) rep = close_walk(ST_HDR_SMALL, '0, '0);
      return walk_done;
    end
    if (at < tag_base) return 1'b0;
    rel = at - tag_base;
    if (rel >= 34'd16) return 1'b0;
    case (rel[3:2])
      2'd0: tag_kind[rel[1:0]*8 +: 8] = item.data_byte;
      2'd1: begin
        tag_len[rel[1:0]*8 +: 8] = item.data_byte;
        if (rel[1:0] == 2'd3) begin
          if (tag_len < 32'd8) begin
            rep = close_walk(ST_TAG_SMALL, '0, '0);
          end else if (tag_kind == TAG_END) begin
            rep = close_walk(ST_NONE, '0, '0);
          end else if (tag_kind != TAG_MODULE) begin
            step     = ({2'b00, tag_len} + 34'd7) & ~34'd7;
            tag_base = tag_base + step;
            tag_kind = '0;
            tag_len  = '0;
            if ({1'b0, tag_base} + 35'd8 > {3'b000, info_size})
              rep = close_walk(ST_NONE, '0, '0);
          end
        end
      end
      2'd2: mod_lo[rel[1:0]*8 +: 8] = item.data_byte;
      default: begin
        mod_hi[rel[1:0]*8 +: 8] = item.data_byte;
        if (rel[1:0] == 2'd3) begin
          if (mod_hi <= mod_lo) rep = close_walk(ST_EMPTY_MOD, '0, '0);
          else rep = close_walk(ST_FOUND, mod_lo, mod_hi);
        end
      end
    endcase
    return walk_done;
  endfunction

  task automatic put_word(input int off, input logic [31:0] w);
    for (int i = 0; i < 4; i++) blk_img[off + i] = w[i*8 +: 8];
  endtask

  task automatic send_byte(input in_item_t item, input bit typed, input out_item_t want);
    out_item_t rep;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_items++;
    if (walk_info_byte(item, rep)) begin
      reports_due.push_back(typed ? want : rep);
    end
  endtask

  task automatic send_block(input int nbytes, input bit marked, input bit typed,
                            input out_item_t want);
    in_item_t item;
    for (int off = 0; off < nbytes; off++) begin
      item.data_byte  = blk_img[off];
      item.first_byte = marked && (off == 0);
      send_byte(item, typed, want);
    end
  endtask

  task automatic fill_noise();
    for (int i = 0; i < 128; i++) blk_img[i] = $urandom_range(255);
  endtask

  task automatic build_random_block(output int len);
    int          off;
    int unsigned r;
    logic [31:0] kind;
    logic [31:0] size;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] tmp;
    fill_noise();
    len = ($urandom_range(99) < 10) ? $urandom_range(23, 4) : $urandom_range(96, 24);
    r = $urandom_range(99);
    if (r < 8) put_word(0, $urandom_range(15));
    else if (r < 20) put_word(0, $urandom());
    else put_word(0, len - 4 + $urandom_range(8));
    off = 8;
    while (off + 16 <= len) begin
      r = $urandom_range(99);
      if (r < 45) begin
        kind = $urandom_range(21, 1);
        if (kind == TAG_MODULE) kind = 32'd4;
      end else if (r < 70) begin
        kind = TAG_MODULE;
      end else if (r < 80) begin
        kind = TAG_END;
      end else begin
        kind = $urandom();
      end
      r = $urandom_range(99);
      if (r < 6) size = $urandom_range(7);
      else if (r < 10) size = $urandom();
      else size = $urandom_range(40, 8);
      put_word(off, kind);
      put_word(off + 4, size);
      if (kind == TAG_MODULE) begin
        lo = $urandom();
        hi = $urandom();
        r  = $urandom_range(99);
        if (r < 10) begin
          hi = lo;
        end else if (r < 75 && hi < lo) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
        put_word(off + 8, lo);
        put_word(off + 12, hi);
      end
      if (kind == TAG_MODULE || kind == TAG_END || size < 8 || size > 40) break;
      off += (size + 7) & ~32'd7;
    end
  endtask

  task automatic log_mismatch(input string what, input out_item_t want, input out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected status %0d start %h end %h, got status %0d start %h end %h",
               $time, what, want.status, want.mod_base, want.mod_end,
               got.status, got.mod_base, got.mod_end);
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid_o && out_ready_i) begin
        if (reports_due.size() == 0) begin
          log_mismatch("unexpected item", '0, out_data_o);
        end else begin
          want = reports_due.pop_front();
          if (out_data_o.status !== want.status || out_data_o.mod_base !== want.mod_base ||
              out_data_o.mod_end !== want.mod_end)
            log_mismatch("field mismatch", want, out_data_o);
        end
      end
    end
  end

  initial begin : sink_ctrl
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin : watchdog
    @(posedge clk_i);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("boot_info_module_tag_finder_top test failed");
    $finish;
  end

  initial begin : stimulus
    blk_row_t    dir_rows [14];
    int          len;
    int unsigned rand_base;
    int unsigned phase;
    in_item_t    item;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    walk_done   = 1'b1;
    rewind_walk();
    // marked, total, type, size, start, end, bytes sent, typed, expected
    dir_rows = '{
      '{1'b0, 32'd16, TAG_END, 32'd8, 32'd0, 32'd0, 8'd16, 1'b0, '0},
      '{1'b1, 32'd15, TAG_END, 32'd0, 32'd0, 32'd0, 8'd4, 1'b1, '{ST_HDR_SMALL, 32'd0, 32'd0}},
      '{1'b1, 32'd0, TAG_END, 32'd0, 32'd0, 32'd0, 8'd4, 1'b1, '{ST_HDR_SMALL, 32'd0, 32'd0}},
      '{1'b1, 32'd16, TAG_MODULE, 32'd7, 32'd0, 32'd0, 8'd16, 1'b1,
        '{ST_TAG_SMALL, 32'd0, 32'd0}},
      '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 8'd16, 1'b1,
        '{ST_TAG_SMALL, 32'd0, 32'd0}},
      '{1'b1, 32'd16, TAG_END, 32'd8, 32'd0, 32'd0, 8'd16, 1'b1, '{ST_NONE, 32'd0, 32'd0}},
      '{1'b1, 32'd24, TAG_MODULE, 32'd16, 32'h1000, 32'h2000, 8'd24, 1'b1,
        '{ST_FOUND, 32'h1000, 32'h2000}},
      '{1'b1, 32'd24, TAG_MODULE, 32'd16, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd24, 1'b1,
        '{ST_EMPTY_MOD, 32'd0, 32'd0}},
      '{1'b1, 32'hFFFF_FFFF, TAG_MODULE, 32'd8, 32'd0, 32'hFFFF_FFFF, 8'd24, 1'b1,
        '{ST_FOUND, 32'd0, 32'hFFFF_FFFF}},
      '{1'b1, 32'd24, 32'd1, 32'd9, 32'd0, 32'd0, 8'd16, 1'b1, '{ST_NONE, 32'd0, 32'd0}},
      '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 8'd16, 1'b1,
        '{ST_NONE, 32'd0, 32'd0}},
      '{1'b1, 32'd32, TAG_MODULE, 32'd16, 32'd5, 32'd9, 8'd10, 1'b0, '0},
      '{1'b1, 32'd40, 32'd5, 32'd8, TAG_MODULE, 32'd16, 8'd40, 1'b0, '0},
      '{1'b1, 32'd16, TAG_MODULE, 32'd16, 32'd7, 32'd8, 8'd24, 1'b1,
        '{ST_FOUND, 32'd7, 32'd8}}
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      fill_noise();
      put_word(0, dir_rows[i].total);
      put_word(8, dir_rows[i].kind);
      put_word(12, dir_rows[i].len);
      put_word(16, dir_rows[i].lo);
      put_word(20, dir_rows[i].hi);
      send_block(dir_rows[i].nbytes, dir_rows[i].marked, dir_rows[i].typed, dir_rows[i].want);
    end

    rand_base = sent_items;
    phase     = 0;
    while (sent_items - rand_base < RAND_ITEMS) begin
      if (phase == 0 && sent_items - rand_base >= RAND_ITEMS / 3) begin
        phase         = 1;
        src_idle_pct  = 50;
        sink_idle_pct = 9;
      end else if (phase == 1 && sent_items - rand_base >= 2 * RAND_ITEMS / 3) begin
        phase         = 2;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_request  = 1'b1;
      end
      build_random_block(len);
      if ($urandom_range(99) < 85) send_block(len, 1'b1, 1'b0, '0);
      else send_block($urandom_range(len - 1, 1), 1'b1, 1'b0, '0);
      if ($urandom_range(99) < 20) begin
        repeat ($urandom_range(4, 1)) begin
          item.data_byte  = $urandom_range(255);
          item.first_byte = 1'b0;
          send_byte(item, 1'b0, '0);
        end
      end
    end
    in_valid_i <= 1'b0;

    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("boot_info_module_tag_finder_top test passed");
    end else begin
      $display("boot_info_module_tag_finder_top test failed");
    end
    $finish;
  end

endmodule
